@@ src/can_raf_pkg.sv @@
// Shared types and constants for the CAN receive acceptance filter.
// No dependencies; imported by every module of the block.
package can_raf_pkg;

    localparam int LIM_W = 7;          // search limit, width holds 0..127
    localparam int NUM_W = 5;          // entry_number field width
    localparam logic [3:0] MAX_LENGTH = 4'd8;

    typedef struct packed {
        logic        remote;
        logic [10:0] id;
        logic [10:0] mask;             // remote bit is always compared
    } filt_entry_t;

    localparam filt_entry_t RESET_ENTRY = '{remote: 1'b0, id: 11'h000, mask: 11'h7FF};

    typedef struct packed {
        logic             write_ok;
        logic             matched;
        logic [NUM_W-1:0] entry_number;
        logic             delivered;
        logic [3:0]       length;
    } filt_result_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } seq_state_t;

endpackage

@@ src/can_rx_acceptance_filter.sv @@
// Top level of the CAN receive acceptance filter: config register, output register.
// Depends on can_raf_pkg, can_raf_table and can_raf_seq.
//
//   channel   handshake                 payload
//   input     in_valid / in_stall       func, entry_*, frame_*
//   output    out_valid / out_stall     write_ok, matched, entry_number, delivered, length
//   config    cfg_wr_en                 cfg_wr_data (active_entries)
//
// A configure word goes straight to the result; a frame word reads entries up to and
// including the first match (at most min(active_entries, ENTRIES)) through the single
// table read port, scanning one entry per cycle.
// Reset clears the configured bits, so no clearing pass is needed.
// A finished word waits in the output register while the next input word is taken.
module can_rx_acceptance_filter
    import can_raf_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [4:0]  entry_index,
    input  logic [10:0] entry_id,
    input  logic [10:0] entry_mask,
    input  logic        entry_remote,
    input  logic [10:0] frame_id,
    input  logic        frame_remote,
    input  logic [3:0]  frame_length_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_ok,
    output logic        matched,
    output logic [4:0]  entry_number,
    output logic        delivered,
    output logic [3:0]  length
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [5:0]       active_reg;
    logic [LIM_W-1:0] limit;
    logic             out_valid_reg, out_valid_next;
    filt_result_t     out_res_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    filt_entry_t      wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    filt_entry_t      rd_data;
    logic             rd_configured;
    logic             res_valid;
    filt_result_t     res;
    logic             res_taken;

    // search no further than the table holds
    assign limit = ({1'b0, active_reg} > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES)
                                                          : {1'b0, active_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            active_reg <= cfg_wr_data;
        end
    end

    can_raf_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .rd_configured (rd_configured)
    );

    can_raf_seq #(
        .IDX_W   (IDX_W)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .limit             (limit),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .entry_index       (entry_index),
        .entry_id          (entry_id),
        .entry_mask        (entry_mask),
        .entry_remote      (entry_remote),
        .frame_id          (frame_id),
        .frame_remote      (frame_remote),
        .frame_length_code (frame_length_code),
        .wr_en             (wr_en),
        .wr_addr           (wr_addr),
        .wr_data           (wr_data),
        .rd_en             (rd_en),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .rd_configured     (rd_configured),
        .res_valid         (res_valid),
        .res               (res),
        .res_taken         (res_taken)
    );

    // load when the output register is empty or being drained
    assign res_taken      = res_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_taken ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_ok     = out_res_reg.write_ok;
    assign matched      = out_res_reg.matched;
    assign entry_number = out_res_reg.entry_number;
    assign delivered    = out_res_reg.delivered;
    assign length       = out_res_reg.length;

endmodule

@@ src/can_raf_table.sv @@
// Filter entry table: synchronous memory with registered read plus per-entry configured bits.
// Depends on can_raf_pkg. An entry never written reads as the reset entry.
module can_raf_table
    import can_raf_pkg::*;
#(
    parameter int ENTRIES = 32,
    parameter int IDX_W   = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  filt_entry_t      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output filt_entry_t      rd_data,
    output logic             rd_configured
);

    filt_entry_t          entry_mem [ENTRIES];
    filt_entry_t          rd_raw_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // substitute reset contents for entries never written
    assign rd_data       = rd_valid_reg ? rd_raw_reg : RESET_ENTRY;
    assign rd_configured = rd_valid_reg;

endmodule

@@ src/can_raf_seq.sv @@
// Sequencer: takes input words, writes entries, scans the table one entry per cycle.
// Depends on can_raf_pkg; drives can_raf_table through its read and write ports.
module can_raf_seq
    import can_raf_pkg::*;
#(
    parameter int IDX_W   = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LIM_W-1:0] limit,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             func,
    input  logic [4:0]       entry_index,
    input  logic [10:0]      entry_id,
    input  logic [10:0]      entry_mask,
    input  logic             entry_remote,
    input  logic [10:0]      frame_id,
    input  logic             frame_remote,
    input  logic [3:0]       frame_length_code,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output filt_entry_t      wr_data,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    input  filt_entry_t      rd_data,
    input  logic             rd_configured,
    output logic             res_valid,
    output filt_result_t     res,
    input  logic             res_taken
);

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [10:0]      rcv_id_reg, rcv_id_next;
    logic             rcv_remote_reg, rcv_remote_next;
    logic [3:0]       len_reg, len_next;
    filt_result_t     res_reg, res_next;

    logic             accept;
    logic             idx_ok;
    logic             hit;
    logic             last;
    logic [3:0]       len_in;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    assign idx_ok  = ({2'b00, entry_index} < limit);
    assign len_in  = (frame_length_code <= MAX_LENGTH) ? frame_length_code : 4'd0;
    assign wr_addr = IDX_W'({2'b00, entry_index});
    assign wr_data = '{remote: entry_remote, id: entry_id, mask: entry_mask};

    // remote bit always takes part in the compare
    assign hit  = ((({rcv_remote_reg, rcv_id_reg} ^ {rd_data.remote, rd_data.id})
                   & {1'b1, rd_data.mask}) == 12'h000);
    assign last = ((LIM_W'(cmp_idx_reg) + LIM_W'(1)) == limit);

    always_comb
    begin
        state_next      = state_reg;
        cmp_idx_next    = cmp_idx_reg;
        rcv_id_next     = rcv_id_reg;
        rcv_remote_next = rcv_remote_reg;
        len_next        = len_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (!func)
                    begin
                        wr_en             = idx_ok;
                        res_next.write_ok = idx_ok;
                        state_next        = ST_RESULT;
                    end
                    else
                    begin
                        rcv_id_next     = frame_id;
                        rcv_remote_next = frame_remote;
                        len_next        = len_in;
                        res_next.length = len_in;
                        if (limit == '0)
                        begin
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            rd_en        = 1'b1;
                            cmp_idx_next = '0;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.matched      = 1'b1;
                    res_next.entry_number = NUM_W'(cmp_idx_reg);
                    res_next.delivered    = rd_configured;
                    res_next.length       = len_reg;
                    state_next            = ST_RESULT;
                end
                else if (last)
                begin
                    res_next.length = len_reg;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    // advance to the next entry
                    rd_en        = 1'b1;
                    rd_addr      = cmp_idx_reg + IDX_W'(1);
                    cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                end
            end
            ST_RESULT:
            begin
                if (res_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        rcv_id_reg     <= rcv_id_next;
        rcv_remote_reg <= rcv_remote_next;
        len_reg        <= len_next;
        res_reg        <= res_next;
    end

endmodule

@@ src/can_raf_checker.sv @@
// Port-level checks for the CAN receive acceptance filter output words.
// No package dependency; bound to can_rx_acceptance_filter at the end of the file.
module can_raf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       write_ok,
    input logic       matched,
    input logic [4:0] entry_number,
    input logic       delivered,
    input logic [3:0] length
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_cfg_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_ok |-> !matched && !delivered && length == 4'd0
                                  && entry_number == 5'd0)
        else $error("configure word carries frame fields");

    a_deliver_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && delivered |-> matched)
        else $error("delivered without a match");

    a_no_match_num: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> entry_number == 5'd0)
        else $error("entry number set without a match");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length <= 4'd8)
        else $error("length above eight");

endmodule

bind can_rx_acceptance_filter can_raf_checker u_can_raf_checker (.*);
